// ----- rtl/core/rfs_pkg.sv -----
// Shared constants, types and the raised-sine table of the ripple field shader.
package rfs_pkg;

  localparam int DROP_SLOTS = 32;
  localparam int SHADES     = 10;
  localparam int COL_BITS   = 10;
  localparam int ROW_BITS   = 9;
  localparam int FRAME_BITS = 16;

  localparam int SLOT_BITS = (DROP_SLOTS > 1) ? $clog2(DROP_SLOTS) : 1;

  // squared offsets: column offset is Q.7 (half cells), row offset Q.8
  localparam int DX_SQ_W = 2 * COL_BITS + 14;
  localparam int DY_SQ_W = 2 * ROW_BITS + 16;
  localparam int RAD_W   = (DX_SQ_W > DY_SQ_W) ? DX_SQ_W : DY_SQ_W;
  localparam int SQ_W    = ((RAD_W + 2) / 2) * 2;
  localparam int DIST_W  = SQ_W / 2;
  localparam int SQ_CNT_W = $clog2(DIST_W);

  // age times wave speed, and the width for comparing it against distance
  localparam int AWS_W = FRAME_BITS + 12;
  localparam int CMP_W = ((AWS_W > DIST_W) ? AWS_W : DIST_W) + 1;

  localparam int DIV_W     = 24;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int SUM_W = 23;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // register indexes of the configuration port
  localparam logic [2:0] CFG_WAVE_SPEED  = 3'd0;
  localparam logic [2:0] CFG_WAVE_LENGTH = 3'd1;
  localparam logic [2:0] CFG_RING_DEPTH  = 3'd2;
  localparam logic [2:0] CFG_FADE_RADIUS = 3'd3;
  localparam logic [2:0] CFG_LIFETIME    = 3'd4;
  localparam logic [2:0] CFG_THRESHOLD   = 3'd5;

  typedef enum logic [1:0] {
    REQ_QUERY   = 2'd0,
    REQ_SPAWN   = 2'd1,
    REQ_ADVANCE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    DIV_IDX   = 2'd0,
    DIV_DFADE = 2'd1,
    DIV_AFADE = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_Q_SLOT,
    S_Q_SQI,
    S_Q_SQRT,
    S_Q_CHECK,
    S_Q_DIDX,
    S_Q_DF_ST,
    S_Q_DDF,
    S_Q_AF_ST,
    S_Q_DAF,
    S_Q_MUL1,
    S_Q_MUL2,
    S_Q_NEXT,
    S_SP_SCAN,
    S_ADV_SCAN,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic     capture;
    logic     slot_clr;
    logic     slot_inc;
    logic     q_load;
    logic     sq_init;
    logic     sq_step;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_step;
    logic     idx_latch;
    logic     df_latch;
    logic     mul1;
    logic     mul2;
    logic     spawn_wr;
    logic     retire;
    logic     frame_inc;
    logic     out_load;
  } rfs_cmd_t;

  typedef struct packed {
    logic slot_valid;
    logic slot_last;
    logic sq_last;
    logic div_last;
    logic win_ok;
    logic out_free;
  } rfs_status_t;

  typedef logic [15:0] sine_tab_t [256];

  // shift-and-subtract floor quotient of two non-negative values
  function automatic int div_floor(int num, int den);
    int q;
    int rem;
    q   = 0;
    rem = 0;
    for (int b = 30; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 1);
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (1 << b);
      end
    end
    return q;
  endfunction

  // raised sine (sin+1)/2 in Q1.15 from a rational approximation
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    int        i;
    int        k;
    int        a;
    int        s;
    for (i = 0; i < 256; i++) begin
      k = i & 127;
      a = k * (128 - k);
      s = div_floor(4 * a * 32768, 20480 - a);
      if (i < 128) t[i] = 16'((32768 + s) >> 1);
      else         t[i] = 16'((32768 - s) >> 1);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ----- rtl/core/rfs_datapath.sv -----
// Datapath: drop table, frame counter, root and divide units, fades, sum and result register.
module rfs_datapath import rfs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [14:0]         cfg_wdata,
  input  logic [1:0]          in_req,
  input  logic [COL_BITS-1:0] in_col,
  input  logic [ROW_BITS-1:0] in_row,
  input  rfs_cmd_t            cmd,
  output rfs_status_t         status,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [3:0]          out_shade,
  output logic                out_painted,
  output logic                out_accepted
);

  // configuration
  logic [11:0] ws_r, wl_r;
  logic [7:0]  rd_r, fr_r, lt_r;
  logic [14:0] thr_r;

  // captured item
  req_t                req_r;
  logic [COL_BITS-1:0] col_r;
  logic [ROW_BITS-1:0] row_r;

  // drop table
  logic                  valid_r    [DROP_SLOTS];
  logic [COL_BITS-1:0]   tab_col_r  [DROP_SLOTS];
  logic [ROW_BITS-1:0]   tab_row_r  [DROP_SLOTS];
  logic [FRAME_BITS-1:0] tab_born_r [DROP_SLOTS];
  logic [FRAME_BITS-1:0] frame_r;
  logic [SLOT_BITS-1:0]  slot_r;

  // per-drop work registers
  logic [DX_SQ_W-1:0]    dx_sq_r;
  logic [DY_SQ_W-1:0]    dy_sq_r;
  logic [FRAME_BITS-1:0] age_r;
  logic [AWS_W-1:0]      aws_r;
  logic [SQ_W-1:0]       sq_v_r, sq_res_r, sq_bit_r;
  logic [SQ_CNT_W-1:0]   sq_cnt_r;
  logic [11:0]           div_rem_r, div_den_r;
  logic [DIV_W-1:0]      div_quo_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic [7:0]            idx_r;
  logic [15:0]           dfade_r, afade_r;
  logic [16:0]           m1_r;
  logic [SUM_W-1:0]      sum_r;
  logic                  acc_r;

  // result register
  logic       out_valid_r;
  logic [3:0] out_shade_r;
  logic       out_painted_r;
  logic       out_accepted_r;

  logic [11:0]           wl_eff, fr_eff, lt_eff;
  logic [FRAME_BITS-1:0] age;
  logic [COL_BITS-1:0]   dcol;
  logic [ROW_BITS-1:0]   drow;
  logic [2*COL_BITS-1:0] dcol_sq;
  logic [2*ROW_BITS-1:0] drow_sq;
  logic [DIST_W-1:0]     dist_cur;
  logic [CMP_W-1:0]      aws_ext, dist_ext, p_full;
  logic [SQ_W-1:0]       sq_trial;
  logic [12:0]           rem_sh;
  logic                  div_ge;
  logic [31:0]           prod1;
  logic [32:0]           prod2;
  logic [SUM_W:0]        sum_add;
  logic [SUM_W+3:0]      sh_prod;
  logic [11:0]           sh_full;
  logic [3:0]            shade_q;
  logic                  paint_q;

  // zero wave length, fade radius and lifetime act as one
  assign wl_eff = (wl_r == 12'd0) ? 12'd1 : wl_r;
  assign fr_eff = (fr_r == 8'd0) ? 12'd1 : {4'd0, fr_r};
  assign lt_eff = (lt_r == 8'd0) ? 12'd1 : {4'd0, lt_r};

  assign age  = frame_r - tab_born_r[slot_r];
  assign dcol = (col_r >= tab_col_r[slot_r]) ? col_r - tab_col_r[slot_r]
                                             : tab_col_r[slot_r] - col_r;
  assign drow = (row_r >= tab_row_r[slot_r]) ? row_r - tab_row_r[slot_r]
                                             : tab_row_r[slot_r] - row_r;

  // full-width squares of the offsets
  assign dcol_sq = {{COL_BITS{1'b0}}, dcol} * {{COL_BITS{1'b0}}, dcol};
  assign drow_sq = {{ROW_BITS{1'b0}}, drow} * {{ROW_BITS{1'b0}}, drow};

  assign dist_cur = sq_res_r[DIST_W-1:0];
  assign aws_ext  = CMP_W'(aws_r);
  assign dist_ext = CMP_W'(dist_cur);
  assign p_full   = aws_ext - dist_ext;
  assign sq_trial = sq_res_r + sq_bit_r;
  assign rem_sh   = {div_rem_r, div_quo_r[DIV_W-1]};
  assign div_ge   = rem_sh >= {1'b0, div_den_r};
  assign prod1    = SINE_TAB[idx_r] * dfade_r;
  assign prod2    = m1_r * afade_r;
  assign sum_add  = {1'b0, sum_r} + (SUM_W+1)'(prod2[32:15]);

  // shade from the saturated sum
  assign sh_prod = sum_r * 4'(SHADES - 1);
  assign sh_full = sh_prod[SUM_W+3:15];
  assign paint_q = sum_r > SUM_W'(thr_r);
  assign shade_q = !paint_q ? 4'd0 :
                   (sh_full > 12'(SHADES - 1)) ? 4'(SHADES - 1) : sh_full[3:0];

  // status to the controller
  always_comb begin
    status.slot_valid = valid_r[slot_r];
    status.slot_last  = slot_r == SLOT_BITS'(DROP_SLOTS - 1);
    status.sq_last    = sq_cnt_r == SQ_CNT_W'(DIST_W - 1);
    status.div_last   = div_cnt_r == DIV_CNT_W'(DIV_W - 1);
    status.win_ok     = (aws_ext > dist_ext) && (p_full < CMP_W'({rd_r, 8'd0})) &&
                        (dist_ext < CMP_W'({fr_eff, 8'd0})) &&
                        (age_r < FRAME_BITS'(lt_eff));
    status.out_free   = !out_valid_r || out_ready;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r  <= 12'd205;
      wl_r  <= 12'd640;
      rd_r  <= 8'd12;
      fr_r  <= 8'd25;
      lt_r  <= 8'd60;
      thr_r <= 15'd1638;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WAVE_SPEED:  ws_r  <= cfg_wdata[11:0];
        CFG_WAVE_LENGTH: wl_r  <= cfg_wdata[11:0];
        CFG_RING_DEPTH:  rd_r  <= cfg_wdata[7:0];
        CFG_FADE_RADIUS: fr_r  <= cfg_wdata[7:0];
        CFG_LIFETIME:    lt_r  <= cfg_wdata[7:0];
        CFG_THRESHOLD:   thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid bits, frame counter and slot pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DROP_SLOTS; i++) valid_r[i] <= 1'b0;
      frame_r <= '0;
      slot_r  <= '0;
    end else begin
      if (cmd.frame_inc) frame_r <= frame_r + 1'b1;
      if (cmd.slot_clr) slot_r <= '0;
      else if (cmd.slot_inc) slot_r <= SLOT_BITS'(slot_r + 1'b1);
      if (cmd.spawn_wr) valid_r[slot_r] <= 1'b1;
      else if (cmd.retire && valid_r[slot_r] && (age > FRAME_BITS'(lt_r)))
        valid_r[slot_r] <= 1'b0;
    end
  end

  // drop payload and captured item
  always_ff @(posedge clk) begin
    if (cmd.spawn_wr) begin
      tab_col_r[slot_r]  <= col_r;
      tab_row_r[slot_r]  <= row_r;
      tab_born_r[slot_r] <= frame_r;
    end
    if (cmd.capture) begin
      req_r <= req_t'(in_req);
      col_r <= in_col;
      row_r <= in_row;
    end
  end

  // squared offsets, integer root and phase product
  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      dx_sq_r <= {dcol_sq, 14'd0};
      dy_sq_r <= {drow_sq, 16'd0};
      age_r   <= age;
    end
    if (cmd.sq_init) begin
      sq_v_r   <= SQ_W'(dx_sq_r) + SQ_W'(dy_sq_r);
      sq_res_r <= '0;
      sq_bit_r <= SQ_W'(1) << (SQ_W - 2);
      sq_cnt_r <= '0;
      aws_r    <= AWS_W'(age_r) * AWS_W'(ws_r);
    end else if (cmd.sq_step) begin
      if (sq_v_r >= sq_trial) begin
        sq_v_r   <= sq_v_r - sq_trial;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
      sq_cnt_r <= SQ_CNT_W'(sq_cnt_r + 1'b1);
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem_r <= '0;
      div_cnt_r <= '0;
      case (cmd.div_sel)
        DIV_IDX: begin
          div_quo_r <= {p_full[15:0], 8'd0};
          div_den_r <= wl_eff;
        end
        DIV_DFADE: begin
          div_quo_r <= DIV_W'({dist_cur[15:0], 7'd0});
          div_den_r <= fr_eff;
        end
        DIV_AFADE: begin
          div_quo_r <= DIV_W'({age_r[7:0], 15'd0});
          div_den_r <= lt_eff;
        end
        default: begin
          div_quo_r <= '0;
          div_den_r <= 12'd1;
        end
      endcase
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? 12'(rem_sh - {1'b0, div_den_r}) : rem_sh[11:0];
      div_quo_r <= {div_quo_r[DIV_W-2:0], div_ge};
      div_cnt_r <= DIV_CNT_W'(div_cnt_r + 1'b1);
    end
  end

  // sine index, fades and weighted contribution
  always_ff @(posedge clk) begin
    if (cmd.idx_latch) idx_r <= 8'd0 - div_quo_r[7:0];
    if (cmd.df_latch) dfade_r <= 16'd32768 - div_quo_r[15:0];
    if (cmd.mul1) begin
      afade_r <= 16'd32768 - div_quo_r[15:0];
      m1_r    <= prod1[31:15];
    end
  end

  // accumulate with saturation; note spawn success
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sum_r <= '0;
      acc_r <= 1'b0;
    end else begin
      if (cmd.mul2) sum_r <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      if (cmd.spawn_wr) acc_r <= 1'b1;
    end
  end

  // result register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_shade_r    <= (req_r == REQ_QUERY) ? shade_q : 4'd0;
      out_painted_r  <= (req_r == REQ_QUERY) && paint_q;
      out_accepted_r <= (req_r == REQ_SPAWN) && acc_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_shade    = out_shade_r;
  assign out_painted  = out_painted_r;
  assign out_accepted = out_accepted_r;

  a_unpainted_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_painted_r |-> out_shade_r == 4'd0)
    else $error("unpainted result carries a shade");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_accepted_r && out_painted_r))
    else $error("result is both a query and a spawn");

  a_spawn_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.spawn_wr |=> valid_r[$past(slot_r)])
    else $error("spawned slot not marked active");

  a_shade_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_shade_r <= 4'(SHADES - 1))
    else $error("shade index out of range");

endmodule

// ----- rtl/core/rfs_ctrl.sv -----
// Controller: sequences queries, spawns and frame advances over the drop slots.
module rfs_ctrl import rfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_req,
  output logic        in_ready,
  input  rfs_status_t status,
  output rfs_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_IDX;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture  = 1'b1;
          cmd.slot_clr = 1'b1;
          case (req_t'(in_req))
            REQ_QUERY:   state_nxt = S_Q_SLOT;
            REQ_SPAWN:   state_nxt = S_SP_SCAN;
            REQ_ADVANCE: begin
              cmd.frame_inc = 1'b1;
              state_nxt     = S_ADV_SCAN;
            end
            default:     state_nxt = S_EMIT;
          endcase
        end
      end
      S_Q_SLOT: begin
        if (status.slot_valid) begin
          cmd.q_load = 1'b1;
          state_nxt  = S_Q_SQI;
        end else begin
          state_nxt = S_Q_NEXT;
        end
      end
      S_Q_SQI: begin
        cmd.sq_init = 1'b1;
        state_nxt   = S_Q_SQRT;
      end
      S_Q_SQRT: begin
        cmd.sq_step = 1'b1;
        if (status.sq_last) state_nxt = S_Q_CHECK;
      end
      S_Q_CHECK: begin
        // skip drops outside the ring or fully faded
        if (status.win_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_IDX;
          state_nxt     = S_Q_DIDX;
        end else begin
          state_nxt = S_Q_NEXT;
        end
      end
      S_Q_DIDX: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = S_Q_DF_ST;
      end
      S_Q_DF_ST: begin
        cmd.idx_latch = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DFADE;
        state_nxt     = S_Q_DDF;
      end
      S_Q_DDF: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = S_Q_AF_ST;
      end
      S_Q_AF_ST: begin
        cmd.df_latch  = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_AFADE;
        state_nxt     = S_Q_DAF;
      end
      S_Q_DAF: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = S_Q_MUL1;
      end
      S_Q_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_Q_MUL2;
      end
      S_Q_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_Q_NEXT;
      end
      S_Q_NEXT: begin
        if (status.slot_last) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_Q_SLOT;
        end
      end
      S_SP_SCAN: begin
        // claim the lowest free slot
        if (!status.slot_valid) begin
          cmd.spawn_wr = 1'b1;
          state_nxt    = S_EMIT;
        end else if (status.slot_last) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.slot_inc = 1'b1;
        end
      end
      S_ADV_SCAN: begin
        cmd.retire = 1'b1;
        if (status.slot_last) state_nxt = S_EMIT;
        else                  cmd.slot_inc = 1'b1;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over an untaken result");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted item not started");

  a_root_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_Q_SQRT && status.sq_last |=> state_r == S_Q_CHECK)
    else $error("root finished without window check");

endmodule

// ----- rtl/core/ripple_field_shader_core.sv -----
// Work per item: a query visits every slot, each active drop runs the 18-step root, and a
// drop inside its ring and not faded also runs three 24-step divides; spawn scans the slots
// up to the first free one, advance scans all slots; a stalled result adds its wait.
// Throughput: one item at a time; the next item is taken the cycle after the result loads.
// Reset (synchronous, rst_n low): all slots inactive, frame zero, registers at defaults.
// Top level of the ripple field shader: stream ports, controller and datapath.
module ripple_field_shader_core import rfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [14:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // col [9:0], row [18:10], zero [23:19]
  input  logic [1:0]  in_tuser,   // req_type [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // shade [3:0], painted [4], accepted [5], zero [7:6]
);

  rfs_cmd_t    cmd;
  rfs_status_t status;
  logic [3:0]  shade;
  logic        painted;
  logic        accepted;

  rfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_req   (in_tuser),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rfs_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_req       (in_tuser),
    .in_col       (in_tdata[COL_BITS-1:0]),
    .in_row       (in_tdata[COL_BITS+ROW_BITS-1:COL_BITS]),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_shade    (shade),
    .out_painted  (painted),
    .out_accepted (accepted)
  );

  assign out_tdata = {2'b00, accepted, painted, shade};

endmodule

// ----- tb/ripple_field_shader_core_tb.sv -----
// Testbench of the ripple field shader core: directed and random items checked against a local predictor.
module ripple_field_shader_core_tb;
  import rfs_pkg::*;

  typedef struct {
    logic [3:0] shade;
    logic       painted;
    logic       accepted;
  } shade_result_t;

  // Scoreboard: tracks drops, frame and registers, predicts and checks results
  class ripple_shade_board;
    logic                  live [DROP_SLOTS];
    logic [COL_BITS-1:0]   drop_col [DROP_SLOTS];
    logic [ROW_BITS-1:0]   drop_row [DROP_SLOTS];
    logic [FRAME_BITS-1:0] drop_born [DROP_SLOTS];
    logic [FRAME_BITS-1:0] frame;
    logic [11:0]           speed;
    logic [11:0]           wlen;
    logic [7:0]            depth;
    logic [7:0]            fade_r;
    logic [7:0]            life;
    logic [14:0]           thresh;
    shade_result_t         pending_shades [$];
    int                    errors;

    function new();
      for (int i = 0; i < DROP_SLOTS; i++) live[i] = 1'b0;
      frame = '0;
      speed = 12'd205;
      wlen = 12'd640;
      depth = 8'd12;
      fade_r = 8'd25;
      life = 8'd60;
      thresh = 15'd1638;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] addr, logic [14:0] val);
      case (addr)
        CFG_WAVE_SPEED:  speed = val[11:0];
        CFG_WAVE_LENGTH: wlen = val[11:0];
        CFG_RING_DEPTH:  depth = val[7:0];
        CFG_FADE_RADIUS: fade_r = val[7:0];
        CFG_LIFETIME:    life = val[7:0];
        CFG_THRESHOLD:   thresh = val;
        default: ;
      endcase
    endfunction

    // floor square root by bitwise trial
    function longint root_of(longint v);
      longint r;
      longint t;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
        t = r | (longint'(1) << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    // raised sine in Q1.15 from the rational approximation
    function longint ridge(longint idx);
      longint k;
      longint a;
      longint s;
      k = idx % 128;
      a = k * (128 - k);
      s = (4 * a * 32768) / (20480 - a);
      return (idx < 128) ? (32768 + s) >>> 1 : (32768 - s) >>> 1;
    endfunction

    function shade_result_t shade_cell(logic [COL_BITS-1:0] c, logic [ROW_BITS-1:0] r);
      shade_result_t res;
      longint wl, fr, lt, sum, age, dx, dy, span, phase, idx, dfade, afade, sh;
      res = '{default: 0};
      wl = (wlen == 0) ? 1 : wlen;
      fr = (fade_r == 0) ? 1 : fade_r;
      lt = (life == 0) ? 1 : life;
      sum = 0;
      for (int i = 0; i < DROP_SLOTS; i++) begin
        if (!live[i]) continue;
        age = longint'(FRAME_BITS'(frame - drop_born[i]));
        dx = (longint'(c) - longint'(drop_col[i])) * 128;
        dy = (longint'(r) - longint'(drop_row[i])) * 256;
        span = root_of(dx * dx + dy * dy);
        phase = span - age * longint'(speed);
        if (!(phase < 0 && phase > -(longint'(depth) * 256))) continue;
        idx = (256 - (((-phase) * 256 / wl) & 255)) & 255;
        dfade = 32768 - (span * 128) / fr;
        afade = 32768 - (age * 32768) / lt;
        if (dfade <= 0 || afade <= 0) continue;
        sum += (((ridge(idx) * dfade) >>> 15) * afade) >>> 15;
        if (sum > 8388607) sum = 8388607;
      end
      if (sum > longint'(thresh)) begin
        sh = (sum * (SHADES - 1)) >>> 15;
        if (sh > SHADES - 1) sh = SHADES - 1;
        res.shade = 4'(sh);
        res.painted = 1'b1;
      end
      return res;
    endfunction

    // apply one accepted item and queue its expected result
    function void note_item(logic [1:0] req, logic [COL_BITS-1:0] c, logic [ROW_BITS-1:0] r);
      shade_result_t res;
      res = '{default: 0};
      if (req == REQ_QUERY) begin
        res = shade_cell(c, r);
      end else if (req == REQ_SPAWN) begin
        for (int i = 0; i < DROP_SLOTS; i++) begin
          if (!live[i]) begin
            live[i] = 1'b1;
            drop_col[i] = c;
            drop_row[i] = r;
            drop_born[i] = frame;
            res.accepted = 1'b1;
            break;
          end
        end
      end else if (req == REQ_ADVANCE) begin
        frame = frame + 1'b1;
        for (int i = 0; i < DROP_SLOTS; i++)
          if (live[i] && FRAME_BITS'(frame - drop_born[i]) > life) live[i] = 1'b0;
      end
      pending_shades.push_back(res);
    endfunction

    function void check_result(logic [7:0] data);
      shade_result_t want;
      if (pending_shades.size() == 0) begin
        $error("unexpected result %h", data);
        errors++;
        return;
      end
      want = pending_shades.pop_front();
      if (data[3:0] !== want.shade) begin
        $error("shade: expected %0d, got %0d", want.shade, data[3:0]);
        errors++;
      end
      if (data[4] !== want.painted) begin
        $error("painted: expected %0d, got %0d", want.painted, data[4]);
        errors++;
      end
      if (data[5] !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, data[5]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [14:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // col [9:0], row [18:10], zero [23:19]
  logic [1:0]  in_tuser;   // req_type [1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // shade [3:0], painted [4], accepted [5], zero [7:6]

  ripple_shade_board board;
  int in_idle;
  int out_idle;
  int drop_c [$];
  int drop_r [$];

  ripple_field_shader_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver stalls at random
  always @(negedge clk) out_tready <= ($urandom_range(99) >= out_idle);

  // check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  task automatic send_item(logic [1:0] req, int c, int r);
    while ($urandom_range(99) < in_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {5'b0, ROW_BITS'(r), COL_BITS'(c)};
    do @(posedge clk); while (!in_tready);
    board.note_item(req, COL_BITS'(c), ROW_BITS'(r));
    @(negedge clk);
  endtask

  // hold input until every expected result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (board.pending_shades.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_regs(int spd, int wl, int dep, int fr, int lt, int th);
    int vals [6];
    vals = '{spd, wl, dep, fr, lt, th};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_wdata <= 15'(vals[i]);
      board.set_reg(3'(i), 15'(vals[i]));
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  // spawn-advance-query sequences near recent drops, with some noise
  task automatic random_phase(int count, int adv_max);
    int sent;
    int pick;
    int n;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        send_item(2'($urandom_range(3)), $urandom_range(1023), $urandom_range(511));
        sent++;
      end else begin
        if (drop_c.size() == 0 || $urandom_range(2) == 0) begin
          drop_c.push_back($urandom_range(1023));
          drop_r.push_back($urandom_range(511));
          if (drop_c.size() > 8) begin
            void'(drop_c.pop_front());
            void'(drop_r.pop_front());
          end
          send_item(REQ_SPAWN, drop_c[$], drop_r[$]);
          sent++;
        end
        n = $urandom_range(adv_max);
        repeat (n) send_item(REQ_ADVANCE, $urandom_range(1023), $urandom_range(511));
        sent += n;
        n = $urandom_range(8, 3);
        repeat (n) begin
          pick = $urandom_range(drop_c.size() - 1);
          send_item(REQ_QUERY, clip(drop_c[pick] + $urandom_range(120) - 60, 1023),
                    clip(drop_r[pick] + $urandom_range(60) - 30, 511));
        end
        sent += n;
      end
      if (sent > count / 2 && sent < count / 2 + 8 && $urandom_range(3) == 0) drain();
    end
    drain();
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    in_idle = 11;
    out_idle = 48;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, corner drops, unused request, rings around a drop
    write_regs(205, 640, 12, 25, 60, 1638);
    send_item(REQ_QUERY, 0, 0);
    send_item(REQ_SPAWN, 0, 0);
    send_item(REQ_SPAWN, 1023, 511);
    send_item(2'd3, 1023, 511);
    repeat (6) send_item(REQ_ADVANCE, 0, 0);
    send_item(REQ_QUERY, 4, 2);
    send_item(REQ_QUERY, 8, 0);
    send_item(REQ_QUERY, 0, 4);
    send_item(REQ_QUERY, 1023, 511);
    send_item(REQ_QUERY, 1015, 507);
    send_item(REQ_QUERY, 1019, 511);
    send_item(REQ_ADVANCE, 0, 0);
    send_item(REQ_QUERY, 6, 3);
    send_item(REQ_QUERY, 512, 256);
    drain();

    // random phases across register extremes and idle patterns
    random_phase(190, 12);
    write_regs(4095, 0, 255, 255, 255, 0);
    in_idle = 48;
    out_idle = 11;
    random_phase(190, 2);
    write_regs(0, 4095, 1, 0, 0, 32767);
    in_idle = 0;
    out_idle = 0;
    random_phase(190, 4);
    write_regs(128, 300, 40, 60, 20, 400);
    random_phase(190, 6);

    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rfs_pkg.sv
rtl/core/rfs_datapath.sv
rtl/core/rfs_ctrl.sv
rtl/core/ripple_field_shader_core.sv
tb/ripple_field_shader_core_tb.sv
